// ----- rtl/dism_pkg.sv -----
// Shared types and constants for the interval set merge block.
package dism_pkg;

	localparam int OP_W           = 1;
	localparam int VALUE_W        = 16;
	localparam int COUNT_W        = 6;
	localparam int DEF_CAPACITY   = 32;
	localparam int DEF_VALUE_BITS = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 1'b0,
		OP_LIST = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UP,
		S_INS,
		S_DN,
		S_LRD,
		S_RSP
	} state_t;

	// Outcome of the shared comparator for one table entry
	typedef struct packed {
		logic start_le_v;
		logic prev_touch;
		logic prev_ge_v;
		logic next_touch;
	} cmp_res_t;

endpackage

// ----- rtl/dism_if.sv -----
// Request and response channel interfaces of the interval set merge block.
interface dism_in_if;
	import dism_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dism_out_if;
	import dism_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] range_start;
	logic [VALUE_W-1:0] range_end;
	logic               last_of_run;
	logic [COUNT_W-1:0] interval_count;
	logic               overflow;
	logic               empty_res;

	modport source (output valid, output range_start, output range_end,
		output last_of_run, output interval_count, output overflow,
		output empty_res, input ready);
	modport sink   (input valid, input range_start, input range_end,
		input last_of_run, input interval_count, input overflow,
		input empty_res, output ready);
endinterface

// ----- rtl/dism_table.sv -----
// Interval table storage: one write port, one registered read port.
module dism_table #(
	parameter int CAPACITY   = dism_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = dism_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  logic [VALUE_BITS-1:0]       wstart,
	input  logic [VALUE_BITS-1:0]       wend,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output logic [VALUE_BITS-1:0]       rstart,
	output logic [VALUE_BITS-1:0]       rend
);
	import dism_pkg::*;

	logic [2*VALUE_BITS-1:0] mem [CAPACITY];
	logic [2*VALUE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wstart, wend};
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rstart = rdata_q[2*VALUE_BITS-1:VALUE_BITS];
	assign rend   = rdata_q[VALUE_BITS-1:0];

endmodule

// ----- rtl/dism_cmp.sv -----
// Shared comparator: places the added value against one entry and its predecessor.
module dism_cmp #(
	parameter int VALUE_BITS = dism_pkg::DEF_VALUE_BITS
) (
	input  logic [VALUE_BITS-1:0] v,
	input  logic [VALUE_BITS-1:0] ent_start,
	input  logic [VALUE_BITS-1:0] pred_end,
	output dism_pkg::cmp_res_t    res
);
	import dism_pkg::*;

	// one extra bit so the top value does not wrap
	logic [VALUE_BITS:0] v_x;
	logic [VALUE_BITS:0] v_inc;
	logic [VALUE_BITS:0] pe_inc;
	logic [VALUE_BITS:0] st_x;

	assign v_x    = {1'b0, v};
	assign st_x   = {1'b0, ent_start};
	assign v_inc  = v_x + {{VALUE_BITS{1'b0}}, 1'b1};
	assign pe_inc = {1'b0, pred_end} + {{VALUE_BITS{1'b0}}, 1'b1};

	always_comb begin
		res.start_le_v = ent_start <= v;
		res.prev_touch = pe_inc >= v_x;
		res.prev_ge_v  = pred_end >= v;
		res.next_touch = v_inc >= st_x;
	end

endmodule

// ----- rtl/dism_ctrl.sv -----
// Sequencer: scans, merges, shifts table entries and drives the result register.
module dism_ctrl #(
	parameter int CAPACITY   = dism_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = dism_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dism_in_if.sink                     req,
	dism_out_if.source                  rsp,
	output logic                        we,
	output logic [$clog2(CAPACITY)-1:0] waddr,
	output logic [VALUE_BITS-1:0]       wstart,
	output logic [VALUE_BITS-1:0]       wend,
	output logic [$clog2(CAPACITY)-1:0] raddr,
	input  logic [VALUE_BITS-1:0]       rstart,
	input  logic [VALUE_BITS-1:0]       rend
);
	import dism_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [CW-1:0]         n_q, n_d;
	logic [CW-1:0]         idx_q, i_q, sh_q;
	logic [VALUE_BITS-1:0] v_q, prev_start_q, pred_end_q;

	logic                  out_valid_q, out_last_q, out_ovf_q, out_empty_q;
	logic [VALUE_W-1:0]    out_start_q, out_end_q;
	logic [COUNT_W-1:0]    out_cnt_q;

	cmp_res_t              cmp;
	logic                  accept, rsp_done;
	logic                  in_range, step, has_prev, mlo, mhi, full, ovf_now;
	logic                  at_end, dn_needed, up_more, dn_more, list_last;
	logic [CW-1:0]         idx_inc;

	logic                  load_res, res_last, res_ovf, res_empty;
	logic [VALUE_BITS-1:0] res_start, res_end;
	logic [CW-1:0]         res_cnt;

	logic [VALUE_W+VALUE_BITS-1:0] v_ext;
	logic [VALUE_W+VALUE_BITS-1:0] start_ext, end_ext;
	logic [COUNT_W+CW-1:0]         cnt_ext;

	dism_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
		.v         (v_q),
		.ent_start (rstart),
		.pred_end  (pred_end_q),
		.res       (cmp)
	);

	assign accept   = req.valid && req.ready;
	assign rsp_done = out_valid_q && rsp.ready;
	assign v_ext    = {{VALUE_BITS{1'b0}}, req.value};

	// decode of the current entry during the scan
	always_comb begin
		idx_inc   = idx_q + CW'(1);
		in_range  = idx_q < n_q;
		step      = in_range && cmp.start_le_v;
		has_prev  = idx_q != '0;
		mlo       = has_prev && cmp.prev_touch;
		mhi       = in_range && cmp.next_touch;
		full      = n_q == CW'(CAPACITY);
		ovf_now   = !mlo && !mhi && full;
		at_end    = idx_q == n_q;
		dn_needed = idx_inc < n_q;
		up_more   = (sh_q - CW'(1)) > i_q;
		dn_more   = sh_q < n_q;
		list_last = idx_inc == n_q;
		n_d       = n_q;
		if (!mlo && !mhi && !full) begin
			n_d = n_q + CW'(1);
		end else if (mlo && mhi) begin
			n_d = n_q - CW'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op_t'(req.operation) == OP_ADD) begin
						state_d = S_SCAN;
					end else if (n_q == '0) begin
						state_d = S_RSP;
					end else begin
						state_d = S_LRD;
					end
				end
			end
			S_SCAN: begin
				if (!step) begin
					if (ovf_now) begin
						state_d = S_RSP;
					end else if (!mlo && !mhi) begin
						state_d = at_end ? S_RSP : S_UP;
					end else if (mlo && mhi) begin
						state_d = dn_needed ? S_DN : S_RSP;
					end else begin
						state_d = S_RSP;
					end
				end
			end
			S_UP: begin
				if (!up_more) begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				state_d = S_RSP;
			end
			S_DN: begin
				if (!dn_more) begin
					state_d = S_RSP;
				end
			end
			S_LRD: begin
				state_d = S_RSP;
			end
			S_RSP: begin
				if (rsp_done) begin
					state_d = out_last_q ? S_IDLE : S_LRD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// table port, handshake and result load
	always_comb begin
		req.ready = 1'b0;
		we        = 1'b0;
		waddr     = '0;
		wstart    = v_q;
		wend      = v_q;
		raddr     = '0;
		load_res  = 1'b0;
		res_start = '0;
		res_end   = '0;
		res_last  = 1'b1;
		res_ovf   = 1'b0;
		res_empty = 1'b0;
		res_cnt   = n_q;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (accept && op_t'(req.operation) == OP_LIST && n_q == '0) begin
					load_res  = 1'b1;
					res_empty = 1'b1;
				end
			end
			S_SCAN: begin
				res_cnt = n_d;
				if (step) begin
					raddr = AW'(idx_inc);
				end else if (ovf_now) begin
					load_res = 1'b1;
					res_ovf  = 1'b1;
				end else if (!mlo && !mhi) begin
					if (at_end) begin
						we       = 1'b1;
						waddr    = AW'(idx_q);
						load_res = 1'b1;
					end else begin
						raddr = AW'(n_q - CW'(1));
					end
				end else if (mlo && !mhi) begin
					we       = 1'b1;
					waddr    = AW'(idx_q - CW'(1));
					wstart   = prev_start_q;
					wend     = cmp.prev_ge_v ? pred_end_q : v_q;
					load_res = 1'b1;
				end else if (!mlo && mhi) begin
					we       = 1'b1;
					waddr    = AW'(idx_q);
					wend     = rend;
					load_res = 1'b1;
				end else begin
					// value bridges the gap between two intervals
					we     = 1'b1;
					waddr  = AW'(idx_q - CW'(1));
					wstart = prev_start_q;
					wend   = rend;
					if (dn_needed) begin
						raddr = AW'(idx_inc);
					end else begin
						load_res = 1'b1;
					end
				end
			end
			S_UP: begin
				we     = 1'b1;
				waddr  = AW'(sh_q);
				wstart = rstart;
				wend   = rend;
				if (up_more) begin
					raddr = AW'(sh_q - CW'(2));
				end
			end
			S_INS: begin
				we       = 1'b1;
				waddr    = AW'(i_q);
				load_res = 1'b1;
			end
			S_DN: begin
				we     = 1'b1;
				waddr  = AW'(sh_q - CW'(1));
				wstart = rstart;
				wend   = rend;
				if (dn_more) begin
					raddr = AW'(sh_q + CW'(1));
				end else begin
					load_res = 1'b1;
				end
			end
			S_LRD: begin
				load_res  = 1'b1;
				res_start = rstart;
				res_end   = rend;
				res_last  = list_last;
			end
			S_RSP: begin
				if (rsp_done && !out_last_q) begin
					raddr = AW'(idx_inc);
				end
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN && !step) begin
				n_q <= n_d;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp_done) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign start_ext = {{VALUE_W{1'b0}}, res_start};
	assign end_ext   = {{VALUE_W{1'b0}}, res_end};
	assign cnt_ext   = {{COUNT_W{1'b0}}, res_cnt};

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					v_q   <= v_ext[VALUE_BITS-1:0];
					idx_q <= '0;
				end
			end
			S_SCAN: begin
				if (step) begin
					idx_q        <= idx_inc;
					prev_start_q <= rstart;
					pred_end_q   <= rend;
				end else begin
					i_q  <= idx_q;
					sh_q <= (mlo && mhi) ? idx_inc : n_q;
				end
			end
			S_UP: begin
				sh_q <= sh_q - CW'(1);
			end
			S_DN: begin
				sh_q <= sh_q + CW'(1);
			end
			S_RSP: begin
				if (rsp_done && !out_last_q) begin
					idx_q <= idx_inc;
				end
			end
			default: begin
				sh_q <= sh_q;
			end
		endcase
		if (load_res) begin
			out_start_q <= start_ext[VALUE_W-1:0];
			out_end_q   <= end_ext[VALUE_W-1:0];
			out_last_q  <= res_last;
			out_cnt_q   <= cnt_ext[COUNT_W-1:0];
			out_ovf_q   <= res_ovf;
			out_empty_q <= res_empty;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.range_start    = out_start_q;
	assign rsp.range_end      = out_end_q;
	assign rsp.last_of_run    = out_last_q;
	assign rsp.interval_count = out_cnt_q;
	assign rsp.overflow       = out_ovf_q;
	assign rsp.empty_res      = out_empty_q;

endmodule

// ----- rtl/disjoint_interval_set_merge_core.sv -----
// Top level of the sorted disjoint interval set with insert and merge.
//
//  channel | dir | payload                                         | handshake
//  req     | in  | operation, value                                | valid/ready
//  rsp     | out | range_start, range_end, last_of_run,            | valid/ready
//          |     | interval_count, overflow, empty_res             |
//
// An add scans the table one entry a cycle up to the insertion point, then moves each
// entry that must shift through the table's read and write ports, then writes and loads
// the result. A list reads each interval only after the previous one is taken from rsp.
// req is ready only when idle; each result waits in the output register until taken.
// Reset empties the table at once; no clearing pass.
module disjoint_interval_set_merge_core #(
	parameter int CAPACITY   = dism_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = dism_pkg::DEF_VALUE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	dism_in_if.sink    req,
	dism_out_if.source rsp
);
	import dism_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [VALUE_BITS-1:0] wstart, wend, rstart, rend;

	dism_table #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_table (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wstart (wstart),
		.wend   (wend),
		.raddr  (raddr),
		.rstart (rstart),
		.rend   (rend)
	);

	dism_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.we     (we),
		.waddr  (waddr),
		.wstart (wstart),
		.wend   (wend),
		.raddr  (raddr),
		.rstart (rstart),
		.rend   (rend)
	);

endmodule
